@@ rtl/core/rmq_pkg.sv @@
// shared types and constants for the matrix-to-quaternion pipeline
package rmq_pkg;

  localparam int unsigned ElemW   = 32;  // matrix element and quaternion field width
  localparam int unsigned NormW   = 31;  // block-scaled magnitude width
  localparam int unsigned RootW   = 32;  // integer square root width
  localparam int unsigned SumW    = 64;  // sum of squares width
  localparam int unsigned RootStg = 32;  // one root bit per stage
  localparam int unsigned Lanes   = 4;
  localparam int unsigned PayW    = Lanes * NormW + Lanes + 1;

  typedef struct packed {
    logic vld;
    logic inv;
  } ctl_t;

endpackage

@@ rtl/core/rmq_prep.sv @@
// pivot selection, block scaling and sum of squares, six stages
module rmq_prep import rmq_pkg::*; #(
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic [9*ElemW-1:0]      mat_i,
  output ctl_t                    ctl_o,
  output logic [SumW-1:0]         sum_o,
  output logic [Lanes*NormW-1:0]  mag_o,
  output logic [Lanes-1:0]        neg_o
);

  localparam int unsigned VW = ((FRAC_BITS > 33) ? FRAC_BITS : 33) + 3;
  localparam int unsigned LW = $clog2(VW + 1);
  localparam logic signed [VW-1:0] One = VW'(1) <<< FRAC_BITS;

  logic signed [VW-1:0] e [9];
  logic signed [VW-1:0] r_c;
  logic signed [VW-1:0] v_c [Lanes];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      e[i] = VW'($signed(mat_i[i*ElemW +: ElemW]));
    end
  end

  // order of tests: x, y, z, then scalar
  always_comb begin
    if (e[0] >= e[4] + e[8]) begin
      r_c = One + e[0] - e[4] - e[8];
      v_c[0] = e[7] - e[5]; v_c[2] = e[1] + e[3]; v_c[3] = e[2] + e[6];
      v_c[1] = (r_c < 0) ? '0 : r_c;
    end else if (e[4] >= e[0] + e[8]) begin
      r_c = One - e[0] + e[4] - e[8];
      v_c[0] = e[2] - e[6]; v_c[1] = e[1] + e[3]; v_c[3] = e[5] + e[7];
      v_c[2] = (r_c < 0) ? '0 : r_c;
    end else if (e[8] >= e[0] + e[4]) begin
      r_c = One - e[0] - e[4] + e[8];
      v_c[0] = e[3] - e[1]; v_c[1] = e[2] + e[6]; v_c[2] = e[5] + e[7];
      v_c[3] = (r_c < 0) ? '0 : r_c;
    end else begin
      r_c = One + e[0] + e[4] + e[8];
      v_c[1] = e[7] - e[5]; v_c[2] = e[2] - e[6]; v_c[3] = e[3] - e[1];
      v_c[0] = (r_c < 0) ? '0 : r_c;
    end
  end

  // stage 1
  ctl_t                 c1_q;
  logic signed [VW-1:0] v1_q [Lanes];
  // stage 2
  ctl_t                 c2_q;
  logic [VW-1:0]        m2_q [Lanes];
  logic [VW-1:0]        mx2_q;
  logic [Lanes-1:0]     n2_q;
  // stage 3
  ctl_t                 c3_q;
  logic [NormW-1:0]     m3_q [Lanes];
  logic [Lanes-1:0]     n3_q;
  // stage 4
  ctl_t                 c4_q;
  logic [2*NormW-1:0]   sq4_q [Lanes];
  logic [NormW-1:0]     m4_q [Lanes];
  logic [Lanes-1:0]     n4_q;
  // stage 5
  ctl_t                 c5_q;
  logic [2*NormW:0]     p5_q [2];
  logic [NormW-1:0]     m5_q [Lanes];
  logic [Lanes-1:0]     n5_q;
  // stage 6
  ctl_t                 c6_q;
  logic [SumW-1:0]      s6_q;
  logic [NormW-1:0]     m6_q [Lanes];
  logic [Lanes-1:0]     n6_q;

  logic [VW-1:0]    mag_c [Lanes];
  logic [Lanes-1:0] neg_c;
  logic [VW-1:0]    mxa_c, mxb_c;
  logic [LW-1:0]    len_c;
  logic [NormW-1:0] sh_c [Lanes];

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      neg_c[i] = v1_q[i][VW-1];
      mag_c[i] = neg_c[i] ? VW'(-v1_q[i]) : VW'(v1_q[i]);
    end
    mxa_c = (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
    mxb_c = (mag_c[2] > mag_c[3]) ? mag_c[2] : mag_c[3];
  end

  // bit length of the largest magnitude, then scale it into [2^30, 2^31)
  always_comb begin
    len_c = '0;
    for (int i = 0; i < VW; i++) begin
      if (mx2_q[i]) len_c = LW'(i + 1);
    end
    for (int i = 0; i < Lanes; i++) begin
      if (len_c > LW'(NormW)) begin
        sh_c[i] = NormW'(m2_q[i] >> (len_c - LW'(NormW)));
      end else begin
        sh_c[i] = NormW'(m2_q[i] << (LW'(NormW) - len_c));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0; c2_q <= '0; c3_q <= '0; c4_q <= '0; c5_q <= '0; c6_q <= '0;
    end else if (en_i) begin
      c1_q <= '{vld: vld_i, inv: (r_c <= 0)};
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
      c5_q <= c4_q;
      c6_q <= c5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < Lanes; i++) begin
        v1_q[i]  <= v_c[i];
        m2_q[i]  <= mag_c[i];
        m3_q[i]  <= sh_c[i];
        sq4_q[i] <= m3_q[i] * m3_q[i];
        m4_q[i]  <= m3_q[i];
        m5_q[i]  <= m4_q[i];
        m6_q[i]  <= m5_q[i];
      end
      mx2_q <= (mxa_c > mxb_c) ? mxa_c : mxb_c;
      n2_q  <= neg_c;
      n3_q  <= n2_q;
      n4_q  <= n3_q;
      n5_q  <= n4_q;
      n6_q  <= n5_q;
      p5_q[0] <= {1'b0, sq4_q[0]} + {1'b0, sq4_q[1]};
      p5_q[1] <= {1'b0, sq4_q[2]} + {1'b0, sq4_q[3]};
      s6_q    <= SumW'(p5_q[0]) + SumW'(p5_q[1]);
    end
  end

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      mag_o[i*NormW +: NormW] = m6_q[i];
    end
  end

  assign ctl_o = c6_q;
  assign sum_o = s6_q;
  assign neg_o = n6_q;

endmodule

@@ rtl/core/rmq_isqrt.sv @@
// pipelined integer square root, one result bit per stage
module rmq_isqrt import rmq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [SumW-1:0]   rad_i,
  input  logic [PayW-1:0]   pay_i,
  output logic              vld_o,
  output logic [RootW-1:0]  root_o,
  output logic [PayW-1:0]   pay_o
);

  logic [SumW-1:0] x_q   [RootStg];
  logic [SumW-1:0] res_q [RootStg];
  logic [PayW-1:0] pay_q [RootStg];
  logic            vld_q [RootStg];

  logic [SumW-1:0] x_d   [RootStg];
  logic [SumW-1:0] res_d [RootStg];

  always_comb begin
    logic [SumW-1:0] xin, rin, bt;
    for (int k = 0; k < RootStg; k++) begin
      xin = (k == 0) ? rad_i : x_q[(k == 0) ? 0 : k - 1];
      rin = (k == 0) ? '0 : res_q[(k == 0) ? 0 : k - 1];
      bt  = SumW'(1) << (SumW - 2 - 2 * k);
      if (xin >= rin + bt) begin
        x_d[k]   = xin - (rin + bt);
        res_d[k] = (rin >> 1) + bt;
      end else begin
        x_d[k]   = xin;
        res_d[k] = rin >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RootStg; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k < RootStg; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q[0] <= pay_i;
      for (int k = 1; k < RootStg; k++) pay_q[k] <= pay_q[k-1];
      for (int k = 0; k < RootStg; k++) begin
        x_q[k]   <= x_d[k];
        res_q[k] <= res_d[k];
      end
    end
  end

  assign vld_o  = vld_q[RootStg-1];
  assign root_o = res_q[RootStg-1][RootW-1:0];
  assign pay_o  = pay_q[RootStg-1];

endmodule

@@ rtl/core/rmq_div.sv @@
// one lane of the pipelined fraction divider with rounding and saturation
module rmq_div import rmq_pkg::*; #(
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NormW-1:0]  num_i,
  input  logic [RootW-1:0]  den_i,
  input  logic              neg_i,
  output logic [ElemW-1:0]  q_o
);

  localparam int unsigned NS = FRAC_BITS + 2;
  localparam int unsigned QW = FRAC_BITS + 2;
  localparam int unsigned MW = (QW > 33) ? QW : 33;

  logic [RootW-1:0] rem_q [NS];
  logic [QW-1:0]    quo_q [NS];
  logic [RootW-1:0] den_q [NS];
  logic             neg_q [NS];
  logic [ElemW-1:0] q_q;

  logic [RootW-1:0] rem_d [NS];
  logic [QW-1:0]    quo_d [NS];

  always_comb begin
    logic [RootW:0] t;
    logic [RootW:0] num_x;
    num_x = (RootW + 1)'(num_i);
    // integer part first, the numerator never exceeds the root
    if (num_x >= {1'b0, den_i}) begin
      rem_d[0] = RootW'(num_x - {1'b0, den_i});
      quo_d[0] = QW'(1);
    end else begin
      rem_d[0] = RootW'(num_x);
      quo_d[0] = '0;
    end
    for (int k = 1; k < NS; k++) begin
      t = {rem_q[k-1], 1'b0};
      if (t >= {1'b0, den_q[k-1]}) begin
        rem_d[k] = RootW'(t - {1'b0, den_q[k-1]});
        quo_d[k] = {quo_q[k-1][QW-2:0], 1'b1};
      end else begin
        rem_d[k] = RootW'(t);
        quo_d[k] = {quo_q[k-1][QW-2:0], 1'b0};
      end
    end
  end

  logic [QW-1:0] rnd_c;
  logic [MW-1:0] mag_c;
  logic [MW-1:0] lim_c;

  // round half away from zero on the magnitude, then clamp to 32 signed bits
  always_comb begin
    rnd_c = quo_q[NS-1] + QW'(1);
    mag_c = MW'(rnd_c >> 1);
    if (neg_q[NS-1]) begin
      lim_c = (mag_c > (MW'(1) << 31)) ? (MW'(1) << 31) : mag_c;
    end else begin
      lim_c = (mag_c > ((MW'(1) << 31) - MW'(1))) ? ((MW'(1) << 31) - MW'(1)) : mag_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
      for (int k = 1; k < NS; k++) begin
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
      for (int k = 0; k < NS; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
      end
      q_q <= neg_q[NS-1] ? ElemW'(-lim_c[ElemW-1:0]) : lim_c[ElemW-1:0];
    end
  end

  assign q_o = q_q;

endmodule

@@ rtl/core/rotation_matrix_to_quaternion.sv @@
// top level: rotation matrix to unit quaternion, fully pipelined
//
// Input stream s_axis: one 3x3 rotation matrix per word, nine signed elements
// with FRAC_BITS fraction bits. Output stream m_axis: the unit quaternion in
// the same format, tuser set when the pivot radicand was not positive and the
// quaternion fields are forced to zero.
// One word is taken every cycle while the output slot is free or m_axis_tready is
// high. Stages in order: pivot selection, block scaling and squaring, 32
// square root stages at one root bit each, FRAC_BITS + 2 divider stages at
// one quotient bit each, and a rounding and clamping register.
// The whole pipeline advances together: while the output word waits on a low
// m_axis_tready, s_axis_tready is low and every stage holds; a free output
// slot or bubble lets it move on. Reset clears all valid bits, so no output
// word is shown until a new matrix has gone through.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int unsigned FRAC_BITS = 30
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [9*ElemW-1:0]   s_axis_tdata_i,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [4*ElemW-1:0]   m_axis_tdata_o,   // q_scalar, q_x, q_y, q_z
  output logic                 m_axis_tuser_o    // invalid
);

  localparam int unsigned DivLat = FRAC_BITS + 3;

  logic en;
  assign en = m_axis_tready_i | ~m_axis_tvalid_o;
  assign s_axis_tready_o = en;

  ctl_t                   prep_ctl;
  logic [SumW-1:0]        prep_sum;
  logic [Lanes*NormW-1:0] prep_mag;
  logic [Lanes-1:0]       prep_neg;

  rmq_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid_i),
    .mat_i  (s_axis_tdata_i),
    .ctl_o  (prep_ctl),
    .sum_o  (prep_sum),
    .mag_o  (prep_mag),
    .neg_o  (prep_neg)
  );

  logic              rt_vld;
  logic [RootW-1:0]  rt_root;
  logic [PayW-1:0]   rt_pay;

  rmq_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (prep_ctl.vld),
    .rad_i  (prep_sum),
    .pay_i  ({prep_ctl.inv, prep_neg, prep_mag}),
    .vld_o  (rt_vld),
    .root_o (rt_root),
    .pay_o  (rt_pay)
  );

  logic [ElemW-1:0] lane_q [Lanes];

  for (genvar i = 0; i < Lanes; i++) begin : g_lane
    rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (rt_pay[i*NormW +: NormW]),
      .den_i (rt_root),
      .neg_i (rt_pay[Lanes*NormW + i]),
      .q_o   (lane_q[i])
    );
  end

  // control travels beside the divider lanes
  ctl_t ctl_q [DivLat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivLat; k++) ctl_q[k] <= '0;
    end else if (en) begin
      ctl_q[0] <= '{vld: rt_vld, inv: rt_pay[PayW-1]};
      for (int k = 1; k < DivLat; k++) ctl_q[k] <= ctl_q[k-1];
    end
  end

  assign m_axis_tvalid_o = ctl_q[DivLat-1].vld;
  assign m_axis_tuser_o  = ctl_q[DivLat-1].inv;
  assign m_axis_tdata_o  = ctl_q[DivLat-1].inv ? '0
                         : {lane_q[3], lane_q[2], lane_q[1], lane_q[0]};

endmodule

@@ rtl/core/rmq_chk.sv @@
// port-level checker for the quaternion pipeline, bound to the top level
module rmq_chk import rmq_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tready_o,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [4*ElemW-1:0] m_axis_tdata_o,
  input logic               m_axis_tuser_o
);

  a_rst_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("output word shown during reset");

  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (m_axis_tready_i || !m_axis_tvalid_o))
    else $error("input ready does not track output slot");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("invalid word carries nonzero quaternion");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled output word changed");

endmodule

bind rotation_matrix_to_quaternion rmq_chk u_rmq_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
